// ===== sv/rhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared constants and pipeline stage types for the 8-bit RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhsv_pkg;

    localparam int CHAN_W   = 8;                  // width of one color channel
    localparam int NUM_W    = 2 * CHAN_W;         // width of a dividend (x * 255)
    localparam int DEN_W    = CHAN_W + 3;         // width of 6 * d
    localparam int DIV_STEPS = CHAN_W;            // one quotient bit per stage
    localparam int TRIAL_W  = DEN_W + DIV_STEPS;  // widest shifted divisor

    localparam logic [CHAN_W-1:0] HUE_FULL         = 8'd255;
    localparam logic [CHAN_W-1:0] HUE_GREEN_OFFSET = 8'd85;
    localparam logic [CHAN_W-1:0] HUE_BLUE_OFFSET  = 8'd170;
    localparam logic [CHAN_W-1:0] HUE_Q_MAX        = 8'd42;   // 255 / 6

    // Hue sector, chosen by the largest channel
    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

    // After max/min search
    typedef struct packed {
        logic [CHAN_W-1:0] mx;
        logic [CHAN_W-1:0] d;
        sector_t           sector;
        logic              neg;
        logic [CHAN_W-1:0] mag;
    } front_t;

    // Carried through the divider stages
    typedef struct packed {
        logic [CHAN_W-1:0] mx;
        logic [DEN_W-1:0]  den;
        sector_t           sector;
        logic              neg;
        logic              d_zero;
        logic [NUM_W-1:0]  sat_rem;
        logic [CHAN_W-1:0] sat_q;
        logic [NUM_W-1:0]  hue_rem;
        logic [CHAN_W-1:0] hue_q;
    } div_t;

endpackage

// ===== sv/rgb_to_hsv_8bit.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_8bit
// Pipelined 8-bit RGB to HSV converter, one pixel per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_ready with red_in, green_in, blue_in.
//   Output channel: out_valid / out_ready with hue_out, sat_out, val_out.
//   A pixel is transferred on either side when valid and ready are both high.
//
//   From input transfer to out_valid a pixel passes one stage for the
//   max/min search, one for the x*255 and 6*d products, eight restoring
//   division stages (one quotient bit each, saturation and hue side by side),
//   and one stage that applies sign, sector offset and wrap.
//   One pixel per cycle when not stalled; the eight-stage divider sets the depth.
//
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready drops; no pixel is lost or repeated. Empty stages never
//   block: while out_valid is low the pipeline keeps advancing.
//   Reset clears all stage valid bits; the pipeline comes up empty and ready.
// ----------------------------------------------------------------------------
module rgb_to_hsv_8bit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] red_in,
    input  logic [7:0] green_in,
    input  logic [7:0] blue_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] hue_out,
    output logic [7:0] sat_out,
    output logic [7:0] val_out
);

    localparam int NS = rhsv_pkg::DIV_STEPS;

    logic                      advance;

    logic                      front_valid_reg;
    rhsv_pkg::front_t          front_reg;
    rhsv_pkg::front_t          front_next;

    logic                      div_valid_reg [0:NS];
    rhsv_pkg::div_t            div_reg       [0:NS];
    rhsv_pkg::div_t            div_next      [0:NS];

    logic                      out_valid_reg;
    logic [7:0]                hue_reg;
    logic [7:0]                sat_reg;
    logic [7:0]                val_reg;
    logic [7:0]                hue_next;
    logic [7:0]                sat_next;

    // Move the whole pipeline unless a result is waiting on a stalled receiver
    assign advance  = out_ready || !out_valid_reg;
    assign in_ready = advance;

    // Find max, min, hue sector and the signed channel difference
    always_comb
    begin
        logic [7:0] mx;
        logic [7:0] mn;
        logic [8:0] diff;
        mx = red_in;
        mn = red_in;
        if (green_in > mx) mx = green_in;
        if (blue_in  > mx) mx = blue_in;
        if (green_in < mn) mn = green_in;
        if (blue_in  < mn) mn = blue_in;
        if (mx == red_in)
        begin
            front_next.sector = rhsv_pkg::SECT_RED;
            diff = {1'b0, green_in} - {1'b0, blue_in};
        end
        else if (mx == green_in)
        begin
            front_next.sector = rhsv_pkg::SECT_GREEN;
            diff = {1'b0, blue_in} - {1'b0, red_in};
        end
        else
        begin
            front_next.sector = rhsv_pkg::SECT_BLUE;
            diff = {1'b0, red_in} - {1'b0, green_in};
        end
        front_next.mx  = mx;
        front_next.d   = mx - mn;
        front_next.neg = diff[8];
        front_next.mag = diff[8] ? 8'(-diff) : diff[7:0];
    end

    // Form dividends x*255 and divisor 6*d
    always_comb
    begin
        div_next[0].mx      = front_reg.mx;
        div_next[0].den     = (11'(front_reg.d) << 2) + (11'(front_reg.d) << 1);
        div_next[0].sector  = front_reg.sector;
        div_next[0].neg     = front_reg.neg;
        div_next[0].d_zero  = (front_reg.d == 8'd0);
        div_next[0].sat_rem = (16'(front_reg.d) << 8) - 16'(front_reg.d);
        div_next[0].sat_q   = '0;
        div_next[0].hue_rem = (16'(front_reg.mag) << 8) - 16'(front_reg.mag);
        div_next[0].hue_q   = '0;
    end

    // Restoring division, one quotient bit per stage, most significant first
    for (genvar k = 0; k < NS; k++)
    begin : g_div
        localparam int SH = NS - 1 - k;
        logic [rhsv_pkg::TRIAL_W-1:0] sat_dv;
        logic [rhsv_pkg::TRIAL_W-1:0] hue_dv;
        logic [rhsv_pkg::TRIAL_W-1:0] sat_ext;
        logic [rhsv_pkg::TRIAL_W-1:0] hue_ext;

        assign sat_dv  = rhsv_pkg::TRIAL_W'(div_reg[k].mx)  << SH;
        assign hue_dv  = rhsv_pkg::TRIAL_W'(div_reg[k].den) << SH;
        assign sat_ext = rhsv_pkg::TRIAL_W'(div_reg[k].sat_rem);
        assign hue_ext = rhsv_pkg::TRIAL_W'(div_reg[k].hue_rem);

        always_comb
        begin
            div_next[k+1] = div_reg[k];
            if (sat_ext >= sat_dv)
            begin
                div_next[k+1].sat_rem   = rhsv_pkg::NUM_W'(sat_ext - sat_dv);
                div_next[k+1].sat_q[SH] = 1'b1;
            end
            if (hue_ext >= hue_dv)
            begin
                div_next[k+1].hue_rem   = rhsv_pkg::NUM_W'(hue_ext - hue_dv);
                div_next[k+1].hue_q[SH] = 1'b1;
            end
        end
    end

    // Apply sign, sector offset and red-sector wrap; gray gives zero
    always_comb
    begin
        logic [7:0] q;
        q = div_reg[NS].hue_q;
        case (div_reg[NS].sector)
            rhsv_pkg::SECT_GREEN:
                hue_next = div_reg[NS].neg ? rhsv_pkg::HUE_GREEN_OFFSET - q
                                           : rhsv_pkg::HUE_GREEN_OFFSET + q;
            rhsv_pkg::SECT_BLUE:
                hue_next = div_reg[NS].neg ? rhsv_pkg::HUE_BLUE_OFFSET - q
                                           : rhsv_pkg::HUE_BLUE_OFFSET + q;
            default:
                hue_next = (div_reg[NS].neg && q != 8'd0) ? rhsv_pkg::HUE_FULL - q : q;
        endcase
        sat_next = div_reg[NS].sat_q;
        if (div_reg[NS].d_zero)
        begin
            hue_next = '0;
            sat_next = '0;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
            for (int i = 0; i <= NS; i++)
            begin
                div_valid_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            front_valid_reg  <= in_valid;
            div_valid_reg[0] <= front_valid_reg;
            for (int i = 1; i <= NS; i++)
            begin
                div_valid_reg[i] <= div_valid_reg[i-1];
            end
            out_valid_reg <= div_valid_reg[NS];
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            front_reg <= front_next;
            for (int i = 0; i <= NS; i++)
            begin
                div_reg[i] <= div_next[i];
            end
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= div_reg[NS].mx;
        end
    end

    assign out_valid = out_valid_reg;
    assign hue_out   = hue_reg;
    assign sat_out   = sat_reg;
    assign val_out   = val_reg;

    // Hue quotient never exceeds 255 / 6
    a_hue_q_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid_reg[NS] && !div_reg[NS].d_zero |-> div_reg[NS].hue_q <= rhsv_pkg::HUE_Q_MAX)
        else $error("hue quotient out of range");

    // A colored pixel always has nonzero saturation
    a_sat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid_reg[NS] && !div_reg[NS].d_zero |-> div_reg[NS].sat_q != 8'd0)
        else $error("zero saturation for colored pixel");

    // Final remainders lie below their divisors
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid_reg[NS] && !div_reg[NS].d_zero |->
            (div_reg[NS].sat_rem < 16'(div_reg[NS].mx)) &&
            (div_reg[NS].hue_rem < 16'(div_reg[NS].den)))
        else $error("division remainder not reduced");

    // Every accepted pixel reaches the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> front_valid_reg)
        else $error("accepted pixel lost at pipeline entry");

    // A held output stage keeps its result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> out_valid_reg && $stable(hue_reg) && $stable(sat_reg))
        else $error("stalled result changed");

endmodule

// ===== test/rgb_to_hsv_8bit_tb.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_8bit_tb
// Self-checking bench for the pipelined 8-bit RGB to HSV converter. A queue of
// pixels (hand-picked corner cases, then a random mix) feeds a valid/ready
// driver. Each transfer is run through a local HSV predictor, and the monitor
// compares every result transfer with the oldest prediction, field by field.
// Both sides take random idle bursts, with a quiet stretch at the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_to_hsv_8bit_tb;

    localparam int CLK_HALF     = 4;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 24;      // pipeline is 11 deep
    localparam int RAND_PIXELS  = 1800;
    localparam int CALM_FROM    = 1500;    // no idling from here on

    localparam int HUE_SPAN     = 255;
    localparam int GREEN_OFFSET = 85;
    localparam int BLUE_OFFSET  = 170;
    localparam int SECTORS      = 6;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
    } hsv_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        bit         drain_first;   // hold until every result is back
        bit         calm;          // no idling once this pixel goes out
    } pixel_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] red_in = 8'd0;
    logic [7:0] green_in = 8'd0;
    logic [7:0] blue_in = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] hue_out;
    logic [7:0] sat_out;
    logic [7:0] val_out;

    pixel_t pixel_q[$];
    hsv_t   hsv_q[$];
    pixel_t next_pix;
    hsv_t   want;
    bit     pix_taken = 1'b0;
    bit     quiet = 1'b0;
    int     tx_gap = 0;
    int     rx_gap = 0;
    int     errors = 0;
    int     cycles = 0;

    rgb_to_hsv_8bit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hue_out   (hue_out),
        .sat_out   (sat_out),
        .val_out   (val_out)
    );

    always #CLK_HALF clk = ~clk;

    // Predict hue, saturation and value of one pixel
    function automatic hsv_t hsv_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int                ri;
        int                gi;
        int                bi;
        int                mx;
        int                mn;
        int                d;
        int                q;
        int                s;
        rhsv_pkg::sector_t sect;
        hsv_t              res;
        ri = int'(r);
        gi = int'(g);
        bi = int'(b);
        mx = ri;
        mn = ri;
        if (gi > mx) mx = gi;
        if (bi > mx) mx = bi;
        if (gi < mn) mn = gi;
        if (bi < mn) mn = bi;
        d = mx - mn;
        res = '0;
        res.val = mx[7:0];
        if (d != 0)
        begin
            s = (d * HUE_SPAN) / mx;
            res.sat = s[7:0];
            // red beats green, green beats blue on a tie
            if (mx == ri)
                sect = rhsv_pkg::SECT_RED;
            else if (mx == gi)
                sect = rhsv_pkg::SECT_GREEN;
            else
                sect = rhsv_pkg::SECT_BLUE;
            // integer division truncates toward zero
            case (sect)
                rhsv_pkg::SECT_RED:
                begin
                    q = ((gi - bi) * HUE_SPAN) / (SECTORS * d);
                    if (q < 0) q = q + HUE_SPAN;
                end
                rhsv_pkg::SECT_GREEN:
                    q = ((bi - ri) * HUE_SPAN) / (SECTORS * d) + GREEN_OFFSET;
                default:
                    q = ((ri - gi) * HUE_SPAN) / (SECTORS * d) + BLUE_OFFSET;
            endcase
            res.hue = q[7:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_v);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, exp_v);
        errors++;
    endtask

    function automatic void add_pixel(int r, int g, int b, bit drain, bit calm);
        pixel_t p;
        p.red = r[7:0];
        p.green = g[7:0];
        p.blue = b[7:0];
        p.drain_first = drain;
        p.calm = calm;
        pixel_q.push_back(p);
    endfunction

    // Favor the channel extremes and their neighbors
    function automatic int pick_extreme_chan();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 1;
            2: return 254;
            3: return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Build the stimulus, release reset, wait for the pipeline to drain
    initial
    begin
        int k;
        int v;
        bit calm;
        // gray pixels, black and white included
        add_pixel(0, 0, 0, 0, 0);
        add_pixel(255, 255, 255, 0, 0);
        add_pixel(128, 128, 128, 0, 0);
        // primaries and smallest maxima
        add_pixel(255, 0, 0, 0, 0);
        add_pixel(0, 255, 0, 0, 0);
        add_pixel(0, 0, 255, 0, 0);
        add_pixel(1, 0, 0, 0, 0);
        add_pixel(0, 1, 0, 0, 0);
        add_pixel(0, 0, 1, 0, 0);
        // ties for the maximum
        add_pixel(255, 255, 0, 0, 0);
        add_pixel(0, 255, 255, 0, 0);
        add_pixel(255, 0, 255, 0, 0);
        add_pixel(1, 1, 0, 0, 0);
        // negative hue in the red sector wraps
        add_pixel(255, 0, 1, 0, 0);
        add_pixel(200, 10, 100, 0, 0);
        add_pixel(255, 254, 255, 0, 0);
        // smallest difference, both signs in green and blue sectors
        add_pixel(255, 254, 254, 0, 0);
        add_pixel(100, 255, 0, 0, 0);
        add_pixel(0, 255, 100, 0, 0);
        add_pixel(0, 1, 255, 0, 0);
        add_pixel(1, 0, 254, 0, 0);
        add_pixel(170, 85, 42, 0, 0);

        // random mix: mostly full range, some gray, some near the extremes, some with two equal channels
        for (int i = 0; i < RAND_PIXELS; i++)
        begin
            calm = (i >= CALM_FROM);
            k = $urandom_range(0, 19);
            if (k < 13)
                add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), (i == 600) || (i == 1200), calm);
            else if (k < 15)
            begin
                v = $urandom_range(0, 255);
                add_pixel(v, v, v, 0, calm);
            end
            else if (k < 18)
                add_pixel(pick_extreme_chan(), pick_extreme_chan(),
                          pick_extreme_chan(), 0, calm);
            else
            begin
                v = $urandom_range(0, 255);
                case ($urandom_range(0, 2))
                    0: add_pixel(v, v, $urandom_range(0, 255), 0, calm);
                    1: add_pixel(v, $urandom_range(0, 255), v, 0, calm);
                    default: add_pixel($urandom_range(0, 255), v, v, 0, calm);
                endcase
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait until every pixel is sent and every result is back
        do
            @(posedge clk);
        while (pixel_q.size() != 0 || in_valid || hsv_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("rgb_to_hsv_8bit_tb: clean");
        else
            $display("rgb_to_hsv_8bit_tb: errors");
        $finish;
    end

    // Drive pixels: hold until transfer, then advance or idle
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || pix_taken))
        begin
            if (tx_gap != 0)
            begin
                tx_gap <= tx_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pixel_q.size() == 0 || (pixel_q[0].drain_first && hsv_q.size() != 0))
                in_valid <= 1'b0;
            else if (!quiet && !pixel_q[0].calm && $urandom_range(0, 9) == 0)
            begin
                tx_gap <= $urandom_range(0, 18);
                in_valid <= 1'b0;
            end
            else
            begin
                next_pix = pixel_q.pop_front();
                red_in <= next_pix.red;
                green_in <= next_pix.green;
                blue_in <= next_pix.blue;
                in_valid <= 1'b1;
                if (next_pix.calm)
                    quiet <= 1'b1;
            end
        end
    end

    // Stall the result side in random bursts
    always @(negedge clk)
    begin
        if (rx_gap != 0)
        begin
            rx_gap <= rx_gap - 1;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            rx_gap <= $urandom_range(0, 18);
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n;
    end

    // Check result transfers, then queue predictions for input transfers
    always @(posedge clk)
    begin
        pix_taken <= in_valid && in_ready;
        if (out_valid && out_ready)
        begin
            if (hsv_q.size() == 0)
                report_mismatch("unexpected result, val_out", int'(val_out), 0);
            else
            begin
                want = hsv_q.pop_front();
                if (hue_out !== want.hue)
                    report_mismatch("hue_out", int'(hue_out), int'(want.hue));
                if (sat_out !== want.sat)
                    report_mismatch("sat_out", int'(sat_out), int'(want.sat));
                if (val_out !== want.val)
                    report_mismatch("val_out", int'(val_out), int'(want.val));
            end
        end
        if (in_valid && in_ready)
            hsv_q.push_back(hsv_of(red_in, green_in, blue_in));
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("rgb_to_hsv_8bit_tb: errors");
            $finish;
        end
    end

endmodule
